>>> hdl/etq_pkg.sv
// ---------------------------------------------------------------------------
// Euler-to-quaternion shared definitions
// Types, constants, the half-degree sine table and the rounding multiply used
// by the angle lanes, the component lanes and the top level.
// ---------------------------------------------------------------------------
package etq_pkg;

   // Default number of fraction bits on the result fields.
   localparam int FRAC_BITS_DEF = 14;

   // Internal fixed point: Q2.30 magnitudes.
   localparam int QI       = 30;
   localparam int MAG_W    = QI + 1;
   localparam int DEG_W    = 9;
   localparam int QUAT_W   = 16;
   localparam int IDX_W    = 8;
   localparam int TABLE_TOP = 180;

   // Pi in Q2.30 and the number of half degrees in a half turn.
   localparam logic [63:0] PI_Q30             = 64'd3373259426;
   localparam logic [63:0] HALF_TURN_HALF_DEG = 64'd360;
   localparam int          SERIES_TERMS       = 12;

   // Divisors (2n)(2n+1) of the alternating sine series.
   localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   // A value in sign and magnitude form; the magnitude never exceeds 1.0.
   typedef struct packed {
      logic              neg;
      logic [MAG_W-1:0]  mag;
   } sm_type;

   // Per-stage advance strobes from the pipeline control.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // How a component lane combines its two products.
   typedef enum logic {
      COMB_ADD,
      COMB_SUB
   } comb_op_type;

   typedef logic [MAG_W-1:0] sin_table_type [0:TABLE_TOP];

   // Sine of k half degrees in Q2.30, evaluated at elaboration only.
   function automatic logic [MAG_W-1:0] sin_half_deg(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (64'(k) * PI_Q30 + HALF_TURN_HALF_DEG / 2) / HALF_TURN_HALF_DEG;
      x2   = (x * x) >> QI;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = ((term * x2) >> QI) / SERIES_DIV[n];
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) <<< QI)) begin
         sum = longint'(1) <<< QI;
      end
      return MAG_W'(sum);
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      for (int unsigned k = 0; k <= TABLE_TOP; k++) begin
         t[k] = sin_half_deg(k);
      end
      return t;
   endfunction

   // Quarter-wave sine table, half-degree steps, Q2.30.
   localparam sin_table_type SIN_TABLE = build_sin_table();

   // Q2.30 product rounded to nearest, ties away from zero.
   function automatic sm_type qmul(input sm_type a, input sm_type b);
      logic [2*MAG_W-1:0] prod;
      logic [2*MAG_W:0]   rnd;
      sm_type             r;
      prod  = a.mag * b.mag;
      rnd   = {1'b0, prod} + ((2*MAG_W+1)'(1) << (QI - 1));
      r.neg = a.neg ^ b.neg;
      r.mag = rnd[QI +: MAG_W];
      return r;
   endfunction

endpackage

>>> hdl/etq_angle_lane.sv
// ---------------------------------------------------------------------------
// Euler-to-quaternion angle lane
// Folds one whole-degree angle onto the quarter-wave table and registers the
// cosine and sine of the half angle in sign and magnitude form.
// ---------------------------------------------------------------------------
module etq_angle_lane (
   input  logic                                clock,
   input  etq_pkg::stage_en_type               stage_en,
   input  logic signed [etq_pkg::DEG_W-1:0]    deg,
   output etq_pkg::sm_type                     half_cos,
   output etq_pkg::sm_type                     half_sin
);

   logic [etq_pkg::DEG_W-1:0] abs_ang;
   logic [etq_pkg::IDX_W-1:0] sin_idx;
   logic [etq_pkg::IDX_W-1:0] cos_idx;
   etq_pkg::sm_type           cos_in;
   etq_pkg::sm_type           sin_in;
   etq_pkg::sm_type           cos_ff;
   etq_pkg::sm_type           sin_ff;

   // The angle in whole degrees is the half angle in half degrees.
   // Half angles beyond a right angle mirror the table and flip the cosine.
   always_comb begin
      abs_ang = deg[etq_pkg::DEG_W-1] ? etq_pkg::DEG_W'(-deg) : etq_pkg::DEG_W'(deg);
      if (abs_ang <= etq_pkg::DEG_W'(etq_pkg::TABLE_TOP)) begin
         sin_idx    = abs_ang[etq_pkg::IDX_W-1:0];
         cos_idx    = etq_pkg::IDX_W'(etq_pkg::DEG_W'(etq_pkg::TABLE_TOP) - abs_ang);
         cos_in.neg = 1'b0;
      end else begin
         sin_idx    = etq_pkg::IDX_W'(etq_pkg::DEG_W'(2 * etq_pkg::TABLE_TOP) - abs_ang);
         cos_idx    = etq_pkg::IDX_W'(abs_ang - etq_pkg::DEG_W'(etq_pkg::TABLE_TOP));
         cos_in.neg = 1'b1;
      end
      cos_in.mag = etq_pkg::SIN_TABLE[cos_idx];
      sin_in.neg = deg[etq_pkg::DEG_W-1];
      sin_in.mag = etq_pkg::SIN_TABLE[sin_idx];
   end

   // Lane output register.
   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign half_cos = cos_ff;
   assign half_sin = sin_ff;

endmodule

>>> hdl/etq_comp_lane.sv
// ---------------------------------------------------------------------------
// Euler-to-quaternion component lane
// Forms two rounded products, adds or subtracts them and rounds the sum to
// the output format with saturation; holds the result register.
// ---------------------------------------------------------------------------
module etq_comp_lane #(
   parameter int FRAC_BITS = etq_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  etq_pkg::stage_en_type                stage_en,
   input  etq_pkg::comb_op_type                 comb_op,
   input  etq_pkg::sm_type                      op_a0,
   input  etq_pkg::sm_type                      op_b0,
   input  etq_pkg::sm_type                      op_a1,
   input  etq_pkg::sm_type                      op_b1,
   output logic signed [etq_pkg::QUAT_W-1:0]    quat
);

   localparam int SUM_W = etq_pkg::MAG_W + 2;
   localparam int SHIFT = etq_pkg::QI - FRAC_BITS;
   localparam logic [SUM_W-1:0] ROUND_HALF =
      (SHIFT > 0) ? (SUM_W'(1) << (SHIFT - 1)) : '0;
   localparam logic [SUM_W-1:0] LIMIT = SUM_W'(1) << FRAC_BITS;

   etq_pkg::sm_type                  prod0_ff;
   etq_pkg::sm_type                  prod1_ff;
   logic signed [SUM_W-1:0]          term0;
   logic signed [SUM_W-1:0]          term1;
   logic signed [SUM_W-1:0]          sum;
   logic                             sum_neg;
   logic [SUM_W-1:0]                 sum_mag;
   logic [SUM_W-1:0]                 rnd_mag;
   logic [SUM_W-1:0]                 sat_mag;
   logic [SUM_W-1:0]                 res;
   logic signed [etq_pkg::QUAT_W-1:0] quat_in;
   logic signed [etq_pkg::QUAT_W-1:0] quat_ff;

   // Product rank.
   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         prod0_ff <= etq_pkg::qmul(op_a0, op_b0);
         prod1_ff <= etq_pkg::qmul(op_a1, op_b1);
      end
   end

   // Sum, round half away from zero, saturate to one, keep the low bits.
   always_comb begin
      term0   = prod0_ff.neg ? -SUM_W'(prod0_ff.mag) : SUM_W'(prod0_ff.mag);
      term1   = prod1_ff.neg ? -SUM_W'(prod1_ff.mag) : SUM_W'(prod1_ff.mag);
      sum     = (comb_op == etq_pkg::COMB_SUB) ? term0 - term1 : term0 + term1;
      sum_neg = sum[SUM_W-1];
      sum_mag = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
      rnd_mag = (sum_mag + ROUND_HALF) >> SHIFT;
      sat_mag = (rnd_mag > LIMIT) ? LIMIT : rnd_mag;
      res     = sum_neg ? SUM_W'(-sat_mag) : sat_mag;
      quat_in = res[etq_pkg::QUAT_W-1:0];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         quat_ff <= quat_in;
      end
   end

   assign quat = quat_ff;

endmodule

>>> hdl/euler_to_quaternion.sv
// ---------------------------------------------------------------------------
// Euler-to-quaternion converter
// Turns a yaw, pitch and roll triple in whole degrees into a unit quaternion
// in signed fixed point, one result per transfer.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  req_yaw_deg, req_pitch_deg, req_roll_deg
//   rsp_      out         rsp_valid/rsp_stall  rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w
//
// One transfer per cycle is accepted while req_stall is low.
// The four stages are the table lookup, the pair products, the second
// multiplier rank and the sum with rounding into the output register.
// Reset clears only the stage valid bits.
// A stall on rsp_ holds the output stage; empty stages upstream still fill,
// so req_stall rises only when every stage holds a transfer.
// ---------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int FRAC_BITS = etq_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_yaw_deg,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_pitch_deg,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_roll_deg,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_x,
   output logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_y,
   output logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_z,
   output logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_w
);

   localparam int STAGES = 4;

   logic [STAGES-1:0]      stage_valid_ff;
   logic [STAGES-1:0]      stage_valid_in;
   etq_pkg::stage_en_type  stage_en;

   etq_pkg::sm_type c1;
   etq_pkg::sm_type s1;
   etq_pkg::sm_type c2;
   etq_pkg::sm_type s2;
   etq_pkg::sm_type c3;
   etq_pkg::sm_type s3;

   etq_pkg::sm_type c1c2_ff;
   etq_pkg::sm_type s1s2_ff;
   etq_pkg::sm_type s1c2_ff;
   etq_pkg::sm_type c1s2_ff;
   etq_pkg::sm_type c3_ff;
   etq_pkg::sm_type s3_ff;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      stage_en.s4 = !stage_valid_ff[3] || !rsp_stall;
      stage_en.s3 = !stage_valid_ff[2] || stage_en.s4;
      stage_en.s2 = !stage_valid_ff[1] || stage_en.s3;
      stage_en.s1 = !stage_valid_ff[0] || stage_en.s2;
      stage_valid_in[0] = stage_en.s1 ? req_valid         : stage_valid_ff[0];
      stage_valid_in[1] = stage_en.s2 ? stage_valid_ff[0] : stage_valid_ff[1];
      stage_valid_in[2] = stage_en.s3 ? stage_valid_ff[1] : stage_valid_ff[2];
      stage_valid_in[3] = stage_en.s4 ? stage_valid_ff[2] : stage_valid_ff[3];
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_stall = !stage_en.s1;
   assign rsp_valid = stage_valid_ff[3];

   // Angle lanes: pitch is slot one, yaw slot two, roll slot three.
   etq_angle_lane u_lane_pitch (
      .clock    (clock),
      .stage_en (stage_en),
      .deg      (req_pitch_deg),
      .half_cos (c1),
      .half_sin (s1)
   );

   etq_angle_lane u_lane_yaw (
      .clock    (clock),
      .stage_en (stage_en),
      .deg      (req_yaw_deg),
      .half_cos (c2),
      .half_sin (s2)
   );

   etq_angle_lane u_lane_roll (
      .clock    (clock),
      .stage_en (stage_en),
      .deg      (req_roll_deg),
      .half_cos (c3),
      .half_sin (s3)
   );

   // Pair products of slots one and two; slot three rides along.
   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         c1c2_ff <= etq_pkg::qmul(c1, c2);
         s1s2_ff <= etq_pkg::qmul(s1, s2);
         s1c2_ff <= etq_pkg::qmul(s1, c2);
         c1s2_ff <= etq_pkg::qmul(c1, s2);
         c3_ff   <= c3;
         s3_ff   <= s3;
      end
   end

   // Component lanes merge the pair products with slot three.
   etq_comp_lane #(.FRAC_BITS(FRAC_BITS)) u_comp_x (
      .clock    (clock),
      .stage_en (stage_en),
      .comb_op  (etq_pkg::COMB_ADD),
      .op_a0    (c1c2_ff),
      .op_b0    (s3_ff),
      .op_a1    (s1s2_ff),
      .op_b1    (c3_ff),
      .quat     (rsp_quat_x)
   );

   etq_comp_lane #(.FRAC_BITS(FRAC_BITS)) u_comp_y (
      .clock    (clock),
      .stage_en (stage_en),
      .comb_op  (etq_pkg::COMB_ADD),
      .op_a0    (s1c2_ff),
      .op_b0    (c3_ff),
      .op_a1    (c1s2_ff),
      .op_b1    (s3_ff),
      .quat     (rsp_quat_y)
   );

   etq_comp_lane #(.FRAC_BITS(FRAC_BITS)) u_comp_z (
      .clock    (clock),
      .stage_en (stage_en),
      .comb_op  (etq_pkg::COMB_SUB),
      .op_a0    (c1s2_ff),
      .op_b0    (c3_ff),
      .op_a1    (s1c2_ff),
      .op_b1    (s3_ff),
      .quat     (rsp_quat_z)
   );

   etq_comp_lane #(.FRAC_BITS(FRAC_BITS)) u_comp_w (
      .clock    (clock),
      .stage_en (stage_en),
      .comb_op  (etq_pkg::COMB_SUB),
      .op_a0    (c1c2_ff),
      .op_b0    (c3_ff),
      .op_a1    (s1s2_ff),
      .op_b1    (s3_ff),
      .quat     (rsp_quat_w)
   );

endmodule

>>> hdl/etq_checker.sv
// ---------------------------------------------------------------------------
// Euler-to-quaternion port checker
// Watches the top-level ports for backpressure, latency and reset behavior.
// ---------------------------------------------------------------------------
module etq_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_yaw_deg,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_pitch_deg,
   input  logic signed [etq_pkg::DEG_W-1:0]     req_roll_deg,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_x,
   input  logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_y,
   input  logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_z,
   input  logic signed [etq_pkg::QUAT_W-1:0]    rsp_quat_w
);

   // The input side only stalls when a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall raised while the output stage can drain");

   // A transfer of all-zero angles comes out with zero x, y and z fields
   // when the output is not stalled in between.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_yaw_deg == 0 && req_pitch_deg == 0 &&
       req_roll_deg == 0) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> (rsp_valid && rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0))
      else $error("zero angles did not give the identity rotation on time");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_quat_x) &&
       $stable(rsp_quat_y) && $stable(rsp_quat_z) && $stable(rsp_quat_w)))
      else $error("stalled result changed or was dropped");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind euler_to_quaternion etq_checker u_etq_checker (.*);

>>> sim/euler_to_quaternion_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Euler-to-quaternion converter testbench
// Sends yaw, pitch and roll triples through the request channel. A built-in
// fixed-point model predicts each quaternion, and every result transfer is
// compared field by field against the oldest prediction. Both channels idle
// at random: the sender works in bursts, and the receiver stalls in
// changing patterns.
// ---------------------------------------------------------------------------
module euler_to_quaternion_tb;

   localparam int DEG_W    = etq_pkg::DEG_W;
   localparam int QUAT_W   = etq_pkg::QUAT_W;
   localparam int OUT_FRAC = etq_pkg::FRAC_BITS_DEF;

   // Internal precision of the model: Q2.30.
   localparam int          FIX_Q       = 30;
   localparam int          OUT_SHIFT   = FIX_Q - OUT_FRAC;
   localparam bit [63:0]   PI_FIX      = 64'd3373259426;
   localparam bit [63:0]   HALF_DEG_PI = 64'd360;
   localparam int          TAYLOR_TERMS = 12;
   localparam int          QUARTER_IDX = 180;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_TAIL     = 12;

   typedef logic signed [DEG_W-1:0]  deg_type;
   typedef logic signed [QUAT_W-1:0] comp_type;

   // One predicted quaternion, with the angles that produced it.
   typedef struct packed {
      deg_type  yaw;
      deg_type  pitch;
      deg_type  roll;
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type w;
   } quat_expect_type;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_LIGHT,
      DRAIN_HEAVY,
      DRAIN_PERIODIC
   } drain_mode_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   deg_type  req_yaw_deg;
   deg_type  req_pitch_deg;
   deg_type  req_roll_deg;
   logic     rsp_valid;
   logic     rsp_stall;
   comp_type rsp_quat_x;
   comp_type rsp_quat_y;
   comp_type rsp_quat_z;
   comp_type rsp_quat_w;

   quat_expect_type quat_expect_q [$];
   int              mismatch_count = 0;
   int              burst_left;
   int              idle_cycles = 0;

   euler_to_quaternion #(
      .FRAC_BITS(OUT_FRAC)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_yaw_deg  (req_yaw_deg),
      .req_pitch_deg(req_pitch_deg),
      .req_roll_deg (req_roll_deg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_quat_x   (rsp_quat_x),
      .rsp_quat_y   (rsp_quat_y),
      .rsp_quat_z   (rsp_quat_z),
      .rsp_quat_w   (rsp_quat_w)
   );

   // Free-running clock, 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Quaternion predictor
   // ------------------------------------------------------------------------

   // Sine of k half degrees in Q2.30 from a truncated Taylor series.
   function automatic longint half_deg_sine(input int unsigned k);
      bit [63:0] ang;
      bit [63:0] ang_sq;
      bit [63:0] term;
      longint    acc;
      ang    = (64'(k) * PI_FIX + HALF_DEG_PI / 2) / HALF_DEG_PI;
      ang_sq = (ang * ang) >> FIX_Q;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * ang_sq) >> FIX_Q) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (longint'(1) <<< FIX_Q)) begin
         acc = longint'(1) <<< FIX_Q;
      end
      return acc;
   endfunction

   // Cosine and sine of half a whole-degree angle; the quarter-wave table is
   // folded so that half angles beyond 90 degrees get a negative cosine.
   function automatic void half_angle_cs(input int deg, output longint cos_v,
                                         output longint sin_v);
      int unsigned mag;
      longint      s_mag;
      mag = (deg < 0) ? -deg : deg;
      if (mag <= QUARTER_IDX) begin
         s_mag = half_deg_sine(mag);
         cos_v = half_deg_sine(QUARTER_IDX - mag);
      end else begin
         s_mag = half_deg_sine(2 * QUARTER_IDX - mag);
         cos_v = -half_deg_sine(mag - QUARTER_IDX);
      end
      sin_v = (deg < 0) ? -s_mag : s_mag;
   endfunction

   // Q2.30 product, rounded to nearest with ties away from zero.
   function automatic longint round_mul(input longint a, input longint b);
      bit        neg;
      bit [63:0] ma;
      bit [63:0] mb;
      bit [63:0] m;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      m   = (ma * mb + (64'd1 << (FIX_Q - 1))) >> FIX_Q;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // Q2.30 sum to the output format: round, saturate to +-1.0, wrap to width.
   function automatic comp_type pack_component(input longint v);
      bit        neg;
      bit [63:0] m;
      neg = v < 0;
      m   = neg ? -v : v;
      if (OUT_SHIFT > 0) begin
         m = (m + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      end
      if (m > (64'd1 << OUT_FRAC)) begin
         m = 64'd1 << OUT_FRAC;
      end
      if (neg) begin
         m = -m;
      end
      return m[QUAT_W-1:0];
   endfunction

   // Pitch takes the first slot, yaw the second and roll the third.
   function automatic quat_expect_type predict_quaternion(input deg_type yaw,
                                                          input deg_type pitch,
                                                          input deg_type roll);
      quat_expect_type e;
      longint          c1, s1, c2, s2, c3, s3;
      longint          c1c2, s1s2, s1c2, c1s2;
      half_angle_cs(int'(pitch), c1, s1);
      half_angle_cs(int'(yaw), c2, s2);
      half_angle_cs(int'(roll), c3, s3);
      c1c2 = round_mul(c1, c2);
      s1s2 = round_mul(s1, s2);
      s1c2 = round_mul(s1, c2);
      c1s2 = round_mul(c1, s2);
      e.yaw   = yaw;
      e.pitch = pitch;
      e.roll  = roll;
      e.x = pack_component(round_mul(c1c2, s3) + round_mul(s1s2, c3));
      e.y = pack_component(round_mul(s1c2, c3) + round_mul(c1s2, s3));
      e.z = pack_component(round_mul(c1s2, c3) - round_mul(s1c2, s3));
      e.w = pack_component(round_mul(c1c2, c3) - round_mul(s1s2, s3));
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // Reporting and checking
   // ------------------------------------------------------------------------

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input comp_type got, input comp_type want,
                              input quat_expect_type e);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got %0d want %0d (yaw %0d pitch %0d roll %0d)",
                                   name, got, want, e.yaw, e.pitch, e.roll));
      end
   endtask

   // Every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      quat_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quat_expect_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %0d %0d %0d %0d",
                                      rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w));
         end else begin
            want = quat_expect_q.pop_front();
            check_field("quat_x", rsp_quat_x, want.x, want);
            check_field("quat_y", rsp_quat_y, want.y, want);
            check_field("quat_z", rsp_quat_z, want.z, want);
            check_field("quat_w", rsp_quat_w, want.w, want);
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: the stall pattern is picked at random and held for a random stretch.
   // ------------------------------------------------------------------------
   initial begin
      drain_mode_type mode;
      int             hold;
      int             period;
      int             phase;
      rsp_stall <= 1'b0;
      mode   = DRAIN_FREE;
      hold   = 0;
      period = 4;
      phase  = 0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            mode   = drain_mode_type'($urandom_range(3));
            hold   = $urandom_range(20, 150);
            period = $urandom_range(2, 8);
         end
         hold--;
         phase = (phase + 1) % period;
         case (mode)
            DRAIN_FREE: begin
               rsp_stall <= 1'b0;
            end
            DRAIN_LIGHT: begin
               rsp_stall <= ($urandom_range(99) < 25);
            end
            DRAIN_HEAVY: begin
               rsp_stall <= ($urandom_range(99) < 75);
            end
            default: begin
               rsp_stall <= (phase < period / 2);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------

   // Offers one angle triple and holds it until the transfer; at the end of a
   // burst the request line may drop for a random gap.
   task automatic send_angles(input deg_type yaw, input deg_type pitch, input deg_type roll);
      int gap;
      req_valid     <= 1'b1;
      req_yaw_deg   <= yaw;
      req_pitch_deg <= pitch;
      req_roll_deg  <= roll;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      quat_expect_q.push_back(predict_quaternion(yaw, pitch, roll));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic deg_type random_deg_in_range();
      return deg_type'(int'($urandom_range(359)) - 180);
   endfunction

   // Any 9-bit code, with a bias toward the points where the table folds.
   function automatic deg_type random_deg_any();
      deg_type d;
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(7))
            0: d = -256;
            1: d = -181;
            2: d = -180;
            3: d = -179;
            4: d = 179;
            5: d = 180;
            6: d = 181;
            default: d = 255;
         endcase
      end else begin
         d = deg_type'($urandom_range(511));
      end
      return d;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Zero attitude, quarter turns on each axis and gimbal lock on pitch.
   task automatic test_axis_angles();
      send_angles(0, 0, 0);
      send_angles(90, 0, 0);
      send_angles(0, 90, 0);
      send_angles(0, 0, 90);
      send_angles(-90, 0, 0);
      send_angles(0, -90, 0);
      send_angles(0, 0, -90);
      send_angles(0, 90, 45);
      send_angles(0, -90, -45);
      send_angles(45, 30, 60);
   endtask

   // Ends of the stated angle range and the smallest nonzero steps.
   task automatic test_range_extremes();
      send_angles(179, 179, 179);
      send_angles(-180, -180, -180);
      send_angles(-180, 0, 0);
      send_angles(0, -180, 0);
      send_angles(0, 0, -180);
      send_angles(1, -1, 1);
      send_angles(-1, 1, -1);
   endtask

   // Codes beyond the stated range, where the half angle passes 90 degrees.
   task automatic test_fold_boundaries();
      send_angles(180, 180, 180);
      send_angles(181, -181, 181);
      send_angles(255, 255, 255);
      send_angles(-256, -256, -256);
      send_angles(-256, 255, 0);
   endtask

   task automatic test_random_attitudes(input int count);
      repeat (count) begin
         send_angles(random_deg_in_range(), random_deg_in_range(), random_deg_in_range());
      end
   endtask

   task automatic test_full_code_space(input int count);
      repeat (count) begin
         send_angles(random_deg_any(), random_deg_any(), random_deg_any());
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_yaw_deg   <= '0;
      req_pitch_deg <= '0;
      req_roll_deg  <= '0;
      burst_left     = $urandom_range(1, 24);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_axis_angles();
      test_range_extremes();
      test_fold_boundaries();
      test_random_attitudes(400);
      test_full_code_space(140);
      req_valid <= 1'b0;

      // Let the pipeline drain; the watchdog covers a hang.
      while (quat_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_TAIL) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
